>>> rtl/core/lfade_pkg.sv
// lfade_pkg: widths, register codes, FSM states and constants for linear_audio_fade.
// No dependencies; used by the channel interfaces and the top level.
package lfade_pkg;

	// field widths
	localparam int SAMPLE_W  = 24;
	localparam int FRAC_W    = 16;
	localparam int GAIN_W    = FRAC_W + 1;
	localparam int POS_W     = 24;
	localparam int MS_W      = 16;
	localparam int RATE_W    = 18;
	localparam int CC_W      = 4;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 2;

	// channel sizing
	localparam int MAX_CHANNELS = 8;
	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > CC_W) ? $clog2(MAX_CHANNELS + 1) : CC_W;

	// length computation: ms * rate / 1000
	localparam int PROD_W   = MS_W + RATE_W;
	localparam int MS_PER_S = 1000;
	localparam int DREM_W   = $clog2(MS_PER_S);
	localparam int ACC_W    = SAMPLE_W + 1;
	localparam int STEP_W   = $clog2(PROD_W + 1);

	localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};
	localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << FRAC_W;
	localparam logic [GAIN_W-1:0] GAIN_ZERO  = '0;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
	localparam logic [CC_W-1:0]   CC_RESET   = CC_W'(2);

	localparam logic ACTION_SAMPLE  = 1'b0;
	localparam logic ACTION_RESTART = 1'b1;
	localparam logic DIR_IN         = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECTION = 2'd0,
		REG_TIME_MS   = 2'd1,
		REG_RATE      = 2'd2,
		REG_CHANNELS  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LMUL,
		ST_LDIV,
		ST_GDIV,
		ST_SMUL,
		ST_FIN
	} state_t;

endpackage

>>> rtl/core/lfade_in_if.sv
// lfade_in_if: input channel of linear_audio_fade (valid/ready plus action and sample).
// Depends on lfade_pkg.
interface lfade_in_if;
	import lfade_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       action;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output action, output sample_in, input ready);
	modport sink   (input valid, input action, input sample_in, output ready);
endinterface

>>> rtl/core/lfade_out_if.sv
// lfade_out_if: result channel of linear_audio_fade (valid/ready plus faded sample).
// Depends on lfade_pkg.
interface lfade_out_if;
	import lfade_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       fade_complete;

	modport source (output valid, output sample_out, output fade_complete, input ready);
	modport sink   (input valid, input sample_out, input fade_complete, output ready);
endinterface

>>> rtl/core/linear_audio_fade.sv
// A sample word's result is registered after the bit-serial multiply; a word that opens a
// frame inside the fade first runs the gain divide, then the bit-serial multiply.
// One word at a time: input ready only while the sequencer is idle, so the next word is
// taken only after the previous word's result has been registered.
// A restart word or config write keeps the sequencer busy through load, length multiply and /1000.
// Reset (arst_n low, async): control and config registers to defaults, fade length 0, position/done cleared.
module linear_audio_fade (
	input  logic                             clk,
	input  logic                             arst_n,
	lfade_in_if.sink                         din,
	lfade_out_if.source                      dout,
	input  logic                             cfg_we,
	input  logic [lfade_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfade_pkg::CFG_W-1:0]      cfg_data
);
	import lfade_pkg::*;

	localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(FRAC_W - 1);
	localparam logic [STEP_W-1:0] LMUL_LAST = STEP_W'(MS_W - 1);
	localparam logic [STEP_W-1:0] LDIV_LAST = STEP_W'(PROD_W - 1);

	// config registers
	logic              dir_q;
	logic [MS_W-1:0]   ms_q;
	logic [RATE_W-1:0] rate_q;
	logic [CC_W-1:0]   cc_q;

	// fade state
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  len_q;
	logic [CH_W-1:0]   chan_q;
	logic [GAIN_W-1:0] gain_q;
	logic              done_q;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] cnt_q;

	// serial datapath
	logic [PROD_W-1:0]          prod_q;
	logic [MS_W-1:0]            ms_sh_q;
	logic [DREM_W-1:0]          lrem_q;
	logic [POS_W-1:0]           grem_q;
	logic [FRAC_W-1:0]          quo_q;
	logic [FRAC_W-1:0]          gsh_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// result word register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       complete_q;

	// ---------------- accept side: frame bookkeeping ----------------
	logic [CNT_W-1:0]  chans;
	logic [CH_W-1:0]   chan_eff;
	logic              frame_start;
	logic              need_div;
	logic [GAIN_W-1:0] hold_gain;
	logic [GAIN_W-1:0] first_gain;
	logic              accept;

	always_comb begin
		if (cc_q == '0) begin
			chans = CNT_W'(1);
		end else if (CNT_W'(cc_q) > CNT_W'(MAX_CHANNELS)) begin
			chans = CNT_W'(MAX_CHANNELS);
		end else begin
			chans = CNT_W'(cc_q);
		end
		// stale index past the frame width restarts the frame
		chan_eff    = (CNT_W'(chan_q) >= chans) ? '0 : chan_q;
		frame_start = (chan_eff == '0);
		// done: hold at the end value; zero length: unity until first frame ends
		if (done_q) begin
			hold_gain = (dir_q == DIR_IN) ? GAIN_ONE : GAIN_ZERO;
		end else begin
			hold_gain = GAIN_ONE;
		end
		need_div   = frame_start && !done_q && (len_q != '0);
		first_gain = frame_start ? hold_gain : gain_q;
	end

	assign accept = din.valid && din.ready;

	// ---------------- serial step logic ----------------
	// length multiply: MSB-first shift-add of rate over ms bits
	logic [PROD_W-1:0] lmul_sum;
	assign lmul_sum = {prod_q[PROD_W-2:0], 1'b0}
		+ PROD_W'(rate_q & {RATE_W{ms_sh_q[MS_W-1]}});

	// length divide by 1000: restoring, quotient shifts into prod_q
	logic [DREM_W:0]   ldiv_r2;
	logic              ldiv_ge;
	logic [DREM_W-1:0] ldiv_rem;
	logic [PROD_W-1:0] ldiv_prod;
	logic [POS_W-1:0]  len_new;

	always_comb begin
		ldiv_r2   = {lrem_q, prod_q[PROD_W-1]};
		ldiv_ge   = (ldiv_r2 >= (DREM_W+1)'(MS_PER_S));
		ldiv_rem  = ldiv_ge ? DREM_W'(ldiv_r2 - (DREM_W+1)'(MS_PER_S)) : ldiv_r2[DREM_W-1:0];
		ldiv_prod = {prod_q[PROD_W-2:0], ldiv_ge};
		// saturate to the position range
		len_new   = (|ldiv_prod[PROD_W-1:POS_W]) ? POS_MAX : ldiv_prod[POS_W-1:0];
	end

	// gain divide: pos * 2^16 / len, one quotient bit per cycle (pos < len here)
	logic [POS_W:0]    gdiv_r2;
	logic              gdiv_ge;
	logic [POS_W-1:0]  gdiv_rem;
	logic [FRAC_W-1:0] gdiv_quo;
	logic [GAIN_W-1:0] gdiv_gain;

	always_comb begin
		gdiv_r2  = {grem_q, 1'b0};
		gdiv_ge  = (gdiv_r2 >= {1'b0, len_q});
		gdiv_rem = gdiv_ge ? POS_W'(gdiv_r2 - {1'b0, len_q}) : gdiv_r2[POS_W-1:0];
		gdiv_quo = {quo_q[FRAC_W-2:0], gdiv_ge};
		if (dir_q == DIR_IN) begin
			gdiv_gain = {1'b0, gdiv_quo};
		end else begin
			gdiv_gain = GAIN_ONE - {1'b0, gdiv_quo};
		end
	end

	// sample multiply: LSB-first, acc = (acc + bit*s) >>> 1 gives floor(s*g/2^16)
	logic signed [ACC_W:0]   smul_sum;
	logic signed [ACC_W-1:0] smul_next;
	always_comb begin
		smul_sum  = {acc_q[ACC_W-1], acc_q}
			+ (gsh_q[0] ? (ACC_W+1)'(sample_q) : '0);
		smul_next = smul_sum[ACC_W:1];
	end

	// frame end update
	logic [CNT_W-1:0] chan_inc;
	logic             frame_end;
	logic [POS_W-1:0] pos_inc;
	logic             done_new;
	always_comb begin
		chan_inc  = CNT_W'(chan_q) + CNT_W'(1);
		frame_end = (chan_inc >= chans);
		pos_inc   = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : pos_q;
		if (frame_end && !done_q) begin
			done_new = (pos_inc >= len_q);
		end else begin
			done_new = done_q;
		end
	end

	// ---------------- sequencer ----------------
	logic fin_fire;
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || dout.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (din.valid) begin
					if (din.action == ACTION_RESTART) begin
						state_d = ST_LOAD;
					end else if (need_div) begin
						state_d = ST_GDIV;
					end else begin
						state_d = ST_SMUL;
					end
				end
			end
			ST_LOAD: begin
				state_d = ST_LMUL;
			end
			ST_LMUL: begin
				if (cnt_q == LMUL_LAST) state_d = ST_LDIV;
			end
			ST_LDIV: begin
				if (cnt_q == LDIV_LAST) state_d = ST_IDLE;
			end
			ST_GDIV: begin
				if (cnt_q == MUL_LAST) state_d = ST_SMUL;
			end
			ST_SMUL: begin
				if (cnt_q == MUL_LAST) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_fire) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// config write restarts the length computation
		if (cfg_we) state_d = ST_LOAD;
	end

	assign din.ready = (state_q == ST_IDLE);

	// control and fade state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dir_q       <= DIR_IN;
			ms_q        <= '0;
			rate_q      <= RATE_RESET;
			cc_q        <= CC_RESET;
			pos_q       <= '0;
			len_q       <= '0;
			chan_q      <= '0;
			gain_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + STEP_W'(1);

			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_DIRECTION: dir_q  <= cfg_data[0];
					REG_TIME_MS:   ms_q   <= cfg_data[MS_W-1:0];
					REG_RATE:      rate_q <= cfg_data[RATE_W-1:0];
					REG_CHANNELS:  cc_q   <= cfg_data[CC_W-1:0];
				endcase
			end

			if (state_q == ST_LOAD) begin
				pos_q  <= '0;
				chan_q <= '0;
				done_q <= 1'b0;
			end
			if (state_q == ST_LDIV && cnt_q == LDIV_LAST) begin
				len_q <= len_new;
			end

			if (accept && din.action == ACTION_SAMPLE) begin
				chan_q <= chan_eff;
				if (frame_start && !need_div) gain_q <= hold_gain;
			end
			if (state_q == ST_GDIV && cnt_q == MUL_LAST) begin
				gain_q <= gdiv_gain;
			end

			if (dout.ready && !fin_fire) out_valid_q <= 1'b0;
			if (fin_fire) begin
				out_valid_q <= 1'b1;
				done_q      <= done_new;
				if (frame_end) begin
					chan_q <= '0;
					if (!done_q) pos_q <= pos_inc;
				end else begin
					chan_q <= CH_W'(chan_inc);
				end
			end
		end
	end

	// serial datapath and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				ms_sh_q <= ms_q;
				prod_q  <= '0;
				lrem_q  <= '0;
			end
			ST_LMUL: begin
				prod_q  <= lmul_sum;
				ms_sh_q <= {ms_sh_q[MS_W-2:0], 1'b0};
			end
			ST_LDIV: begin
				prod_q <= ldiv_prod;
				lrem_q <= ldiv_rem;
			end
			ST_GDIV: begin
				grem_q <= gdiv_rem;
				quo_q  <= gdiv_quo;
				if (cnt_q == MUL_LAST) begin
					gsh_q <= gdiv_gain[FRAC_W-1:0];
					acc_q <= '0;
				end
			end
			ST_SMUL: begin
				acc_q <= smul_next;
				gsh_q <= {1'b0, gsh_q[FRAC_W-1:1]};
			end
			ST_IDLE: begin
				if (accept) begin
					sample_q <= din.sample_in;
					grem_q   <= pos_q;
					quo_q    <= '0;
					acc_q    <= '0;
					gsh_q    <= first_gain[FRAC_W-1:0];
				end
			end
			ST_FIN: begin
				if (fin_fire) begin
					// unity gain passes the sample through untouched
					sample_out_q <= gain_q[GAIN_W-1] ? sample_q : acc_q[SAMPLE_W-1:0];
					complete_q   <= done_new;
				end
			end
			default: begin
			end
		endcase
	end

	assign dout.valid         = out_valid_q;
	assign dout.sample_out    = sample_out_q;
	assign dout.fade_complete = complete_q;

endmodule
